// ----- rtl/core/hjbp_pkg.sv -----
package hjbp_pkg;

  // Default sizes of the build table and of the command queue.
  localparam int TABLE_DEPTH = 64;
  localparam int QUEUE_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int KIND_W = 2;
  localparam int KEY_W  = 32;
  localparam int HDL_W  = 32;

  // Request kinds as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic ST_MATCH = 1'b0;
  localparam logic ST_DROP  = 1'b1;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_PROBE,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic signed [KEY_W-1:0]  key;
    logic [HDL_W-1:0]         payload;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

  // Status of the back end, watched at the top level.
  typedef struct packed {
    logic       busy;
    logic [7:0] count;
  } bk_stat_t;

endpackage

// ----- rtl/core/hjbp_front.sv -----
module hjbp_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hjbp_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [hjbp_pkg::KEY_W-1:0]    in_key,
  input  logic [hjbp_pkg::HDL_W-1:0]           in_payload,
  output logic                                 push,
  output hjbp_pkg::cmd_t                       push_cmd,
  input  logic                                 q_full
);

  logic           hold_vld_r;
  logic           hold_vld_nxt;
  hjbp_pkg::cmd_t hold_cmd_r;
  hjbp_pkg::cmd_t cls_cmd;
  logic           cls_keep;
  logic           in_acc;

  // Classify the incoming request; an unknown kind is accepted and dropped.
  always_comb begin
    cls_cmd.key     = in_key;
    cls_cmd.payload = in_payload;
    cls_keep        = 1'b1;
    case (in_kind)
      hjbp_pkg::KIND_INSERT: cls_cmd.op = hjbp_pkg::OP_INSERT;
      hjbp_pkg::KIND_PROBE:  cls_cmd.op = hjbp_pkg::OP_PROBE;
      hjbp_pkg::KIND_CLEAR:  cls_cmd.op = hjbp_pkg::OP_CLEAR;
      default: begin
        cls_cmd.op = hjbp_pkg::OP_CLEAR;
        cls_keep   = 1'b0;
      end
    endcase
  end

  // The holding register drains into the queue whenever the queue has room.
  assign push     = hold_vld_r && !q_full;
  assign push_cmd = hold_cmd_r;
  assign in_ready = !hold_vld_r || push;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (push) begin
      hold_vld_nxt = 1'b0;
    end
    if (in_acc && cls_keep) begin
      hold_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // The request itself needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc && cls_keep) begin
      hold_cmd_r <= cls_cmd;
    end
  end

endmodule

// ----- rtl/core/hjbp_fifo.sv -----
module hjbp_fifo #(
  parameter int QUEUE_DEPTH = hjbp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hjbp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_vld,
  output hjbp_pkg::cmd_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  hjbp_pkg::cmd_t q_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW-1:0]  rd_ptr_nxt;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_vld;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/hjbp_back.sv -----
module hjbp_back #(
  parameter int TABLE_DEPTH = hjbp_pkg::TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_vld,
  input  hjbp_pkg::cmd_t                       head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic signed [hjbp_pkg::KEY_W-1:0]    out_match_key,
  output logic [hjbp_pkg::HDL_W-1:0]           out_probe_handle,
  output logic [hjbp_pkg::HDL_W-1:0]           out_build_handle,
  output logic                                 out_last,
  output hjbp_pkg::bk_stat_t                   stat
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Build table storage.
  logic [hjbp_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [hjbp_pkg::HDL_W-1:0] hdl_mem [TABLE_DEPTH];

  hjbp_pkg::bk_state_t state_r;
  hjbp_pkg::bk_state_t state_nxt;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       idx_nxt;
  logic                cmp_vld_r;
  logic                cmp_vld_nxt;
  logic                pend_vld_r;
  logic                pend_vld_nxt;
  logic [hjbp_pkg::HDL_W-1:0] pend_hdl_r;
  logic [hjbp_pkg::HDL_W-1:0] pend_hdl_nxt;
  logic signed [hjbp_pkg::KEY_W-1:0] cur_key_r;
  logic signed [hjbp_pkg::KEY_W-1:0] cur_key_nxt;
  logic [hjbp_pkg::HDL_W-1:0] cur_hdl_r;
  logic [hjbp_pkg::HDL_W-1:0] cur_hdl_nxt;
  logic [hjbp_pkg::KEY_W-1:0] rd_key_r;
  logic [hjbp_pkg::HDL_W-1:0] rd_hdl_r;

  logic                out_vld_r;
  logic                out_vld_nxt;
  logic                out_status_r;
  logic                out_status_nxt;
  logic signed [hjbp_pkg::KEY_W-1:0] out_key_r;
  logic signed [hjbp_pkg::KEY_W-1:0] out_key_nxt;
  logic [hjbp_pkg::HDL_W-1:0] out_phdl_r;
  logic [hjbp_pkg::HDL_W-1:0] out_phdl_nxt;
  logic [hjbp_pkg::HDL_W-1:0] out_bhdl_r;
  logic [hjbp_pkg::HDL_W-1:0] out_bhdl_nxt;
  logic                out_last_r;
  logic                out_last_nxt;

  logic                can_push;
  logic                full;
  logic                hit;
  logic                more;
  logic                mem_we;
  logic                rd_en;

  assign can_push = !out_vld_r || out_ready;
  assign full     = (cnt_r == CW'(TABLE_DEPTH));
  assign hit      = cmp_vld_r && (rd_key_r == cur_key_r);
  assign more     = (idx_r < cnt_r);

  // Sequencer: one request at a time; a probe reads one entry per cycle unless stalled
  // on the output, and holds the latest match back so the final one is marked last.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    pend_vld_nxt   = pend_vld_r;
    pend_hdl_nxt   = pend_hdl_r;
    cur_key_nxt    = cur_key_r;
    cur_hdl_nxt    = cur_hdl_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_phdl_nxt   = out_phdl_r;
    out_bhdl_nxt   = out_bhdl_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      hjbp_pkg::BK_IDLE: begin
        if (q_vld && can_push) begin
          pop = 1'b1;
          case (head.op)
            hjbp_pkg::OP_INSERT: begin
              if (full) begin
                out_vld_nxt    = 1'b1;
                out_status_nxt = hjbp_pkg::ST_DROP;
                out_key_nxt    = head.key;
                out_phdl_nxt   = head.payload;
                out_bhdl_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            hjbp_pkg::OP_PROBE: begin
              state_nxt    = hjbp_pkg::BK_SCAN;
              cur_key_nxt  = head.key;
              cur_hdl_nxt  = head.payload;
              idx_nxt      = '0;
              cmp_vld_nxt  = 1'b0;
              pend_vld_nxt = 1'b0;
            end
            hjbp_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      hjbp_pkg::BK_SCAN: begin
        if (cmp_vld_r || more) begin
          // Stall only when an earlier match must leave but cannot.
          if (!(hit && pend_vld_r && !can_push)) begin
            if (hit) begin
              if (pend_vld_r) begin
                out_vld_nxt    = 1'b1;
                out_status_nxt = hjbp_pkg::ST_MATCH;
                out_key_nxt    = cur_key_r;
                out_phdl_nxt   = cur_hdl_r;
                out_bhdl_nxt   = pend_hdl_r;
                out_last_nxt   = 1'b0;
              end
              pend_vld_nxt = 1'b1;
              pend_hdl_nxt = rd_hdl_r;
            end
            if (more) begin
              rd_en       = 1'b1;
              idx_nxt     = idx_r + 1'b1;
              cmp_vld_nxt = 1'b1;
            end else begin
              cmp_vld_nxt = 1'b0;
            end
          end
        end else if (pend_vld_r) begin
          if (can_push) begin
            out_vld_nxt    = 1'b1;
            out_status_nxt = hjbp_pkg::ST_MATCH;
            out_key_nxt    = cur_key_r;
            out_phdl_nxt   = cur_hdl_r;
            out_bhdl_nxt   = pend_hdl_r;
            out_last_nxt   = 1'b1;
            pend_vld_nxt   = 1'b0;
            state_nxt      = hjbp_pkg::BK_IDLE;
          end
        end else begin
          state_nxt = hjbp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = hjbp_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= hjbp_pkg::BK_IDLE;
      cnt_r      <= '0;
      idx_r      <= '0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Data registers carry no reset.
  always_ff @(posedge clk) begin
    pend_hdl_r   <= pend_hdl_nxt;
    cur_key_r    <= cur_key_nxt;
    cur_hdl_r    <= cur_hdl_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_phdl_r   <= out_phdl_nxt;
    out_bhdl_r   <= out_bhdl_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Table write on insert, registered read during a probe.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[cnt_r[AW-1:0]] <= head.key;
      hdl_mem[cnt_r[AW-1:0]] <= head.payload;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[idx_r[AW-1:0]];
      rd_hdl_r <= hdl_mem[idx_r[AW-1:0]];
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_match_key    = out_key_r;
  assign out_probe_handle = out_phdl_r;
  assign out_build_handle = out_bhdl_r;
  assign out_last         = out_last_r;

  assign stat.busy  = (state_r != hjbp_pkg::BK_IDLE);
  assign stat.count = 8'(cnt_r);

endmodule

// ----- rtl/core/hash_join_build_probe.sv -----
// Hash join build and probe engine.
// Input requests (in_valid/in_ready) carry a kind, a key and a payload handle.
// An insert appends the row to the build table, a probe returns one result
// per stored row with an equal key in insertion order, and a clear empties
// the table. A request of unknown kind is accepted and discarded.
// Results (out_valid/out_ready) are either joins (status 0) or a report of an
// insert dropped because the table was full (status 1); last marks the final
// result of a request. A probe without a match gives no result.
// A request passes a holding register and a short command queue before the
// back end, so requests are still accepted during a probe until the queue
// fills. A probe reads the table through its single read port, one entry per
// cycle while no held match waits on a stalled receiver. A dropped insert
// passes the holding register and the queue and is reported from the result
// register. When the receiver stalls, the result register holds and the
// probe scan pauses once a further match is waiting. Reset empties the table
// and the queue; no clearing pass over the table is needed.
module hash_join_build_probe #(
  parameter int TABLE_DEPTH = hjbp_pkg::TABLE_DEPTH,
  parameter int QUEUE_DEPTH = hjbp_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hjbp_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [hjbp_pkg::KEY_W-1:0]    in_key,
  input  logic [hjbp_pkg::HDL_W-1:0]           in_payload,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic signed [hjbp_pkg::KEY_W-1:0]    out_match_key,
  output logic [hjbp_pkg::HDL_W-1:0]           out_probe_handle,
  output logic [hjbp_pkg::HDL_W-1:0]           out_build_handle,
  output logic                                 out_last
);

  logic               push;
  hjbp_pkg::cmd_t     push_cmd;
  logic               q_full;
  logic               q_vld;
  logic               pop;
  hjbp_pkg::cmd_t     head;
  hjbp_pkg::bk_stat_t stat;

  // Front end: accepts and classifies requests.
  hjbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_key     (in_key),
    .in_payload (in_payload),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  // Command queue between the two halves.
  hjbp_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_vld    (q_vld),
    .head     (head)
  );

  // Back end: build table, probe scan and result register.
  hjbp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_match_key    (out_match_key),
    .out_probe_handle (out_probe_handle),
    .out_build_handle (out_build_handle),
    .out_last         (out_last),
    .stat             (stat)
  );

`ifndef SYNTHESIS
  // The table never holds more rows than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= 8'(TABLE_DEPTH))
    else $error("build table count exceeds its depth");

  // A dropped insert is always a single, final result without a build row.
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == hjbp_pkg::ST_DROP) |-> (out_last && out_build_handle == '0))
    else $error("dropped insert result malformed");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overflow");

  // The back end takes a command only when one is waiting and it is idle.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_vld && !stat.busy))
    else $error("command taken from an empty queue or while busy");
`endif

endmodule

// ----- tb/hash_join_build_probe_check.sv -----
`timescale 1ns / 100ps

module hash_join_build_probe_check #(
  parameter int TABLE_DEPTH = hjbp_pkg::TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [hjbp_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [hjbp_pkg::KEY_W-1:0] in_key,
  input  logic [hjbp_pkg::HDL_W-1:0]        in_payload,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_status,
  input  logic signed [hjbp_pkg::KEY_W-1:0] out_match_key,
  input  logic [hjbp_pkg::HDL_W-1:0]        out_probe_handle,
  input  logic [hjbp_pkg::HDL_W-1:0]        out_build_handle,
  input  logic                              out_last,
  output int                                join_errors,
  output int                                joins_outstanding
);

  import hjbp_pkg::*;

  typedef struct packed {
    logic                    status;
    logic signed [KEY_W-1:0] match_key;
    logic [HDL_W-1:0]        probe_handle;
    logic [HDL_W-1:0]        build_handle;
    logic                    last;
  } join_row_t;

  // Private copy of the build table.
  logic [KEY_W-1:0] built_keys    [TABLE_DEPTH];
  logic [HDL_W-1:0] built_handles [TABLE_DEPTH];
  int               built_rows;

  // Joined rows and drop reports still owed by the block, oldest first.
  join_row_t pending_joins[$];
  int        results_seen;

  initial begin
    join_errors       = 0;
    joins_outstanding = 0;
    built_rows        = 0;
    results_seen      = 0;
  end

  // Works out what one accepted request must produce and updates the table.
  task automatic predict_join(input logic [KIND_W-1:0] kind,
                              input logic [KEY_W-1:0] key,
                              input logic [HDL_W-1:0] payload);
    int        hits;
    int        seen;
    join_row_t row;
    case (kind)
      KIND_INSERT: begin
        if (built_rows < TABLE_DEPTH) begin
          built_keys[built_rows]    = key;
          built_handles[built_rows] = payload;
          built_rows++;
        end else begin
          row = '{ST_DROP, key, payload, '0, 1'b1};
          pending_joins = {pending_joins, row};
        end
      end
      KIND_PROBE: begin
        // Count the matches first so that the final one can carry last.
        hits = 0;
        for (int i = 0; i < built_rows; i++)
          if (built_keys[i] == key) hits++;
        seen = 0;
        for (int i = 0; i < built_rows; i++) begin
          if (built_keys[i] == key) begin
            seen++;
            row = '{ST_MATCH, key, payload, built_handles[i], seen == hits};
            pending_joins = {pending_joins, row};
          end
        end
      end
      KIND_CLEAR: built_rows = 0;
      default: ;
    endcase
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      join_errors++;
      if (join_errors <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
    end
  endtask

  // Compares one delivered result with the oldest expectation.
  task automatic check_result();
    join_row_t want;
    if (pending_joins.size() == 0) begin
      join_errors++;
      if (join_errors <= 10)
        $display("result %0d: none expected, got status %b key %h probe %h build %h last %b",
                 results_seen, out_status, out_match_key, out_probe_handle,
                 out_build_handle, out_last);
    end else begin
      want = pending_joins.pop_front();
      compare_field("status", 32'(want.status), 32'(out_status));
      compare_field("match_key", want.match_key, out_match_key);
      compare_field("probe_handle", want.probe_handle, out_probe_handle);
      compare_field("build_handle", want.build_handle, out_build_handle);
      compare_field("last", 32'(want.last), 32'(out_last));
    end
    results_seen++;
  endtask

  // Both channels are sampled at the edge at which a request or result moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_join(in_kind, in_key, in_payload);
      if (out_valid && out_ready)
        check_result();
    end
    joins_outstanding <= pending_joins.size();
  end

endmodule

// ----- tb/hash_join_build_probe_test.sv -----
`timescale 1ns / 100ps

module hash_join_build_probe_test;

  import hjbp_pkg::*;

  // A kind the block accepts and discards.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [KIND_W-1:0]       in_kind = KIND_CLEAR;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [HDL_W-1:0]        in_payload = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_status;
  logic signed [KEY_W-1:0] out_match_key;
  logic [HDL_W-1:0]        out_probe_handle;
  logic [HDL_W-1:0]        out_build_handle;
  logic                    out_last;

  int join_errors;
  int joins_outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;

  always #4 clk = ~clk;

  hash_join_build_probe u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_match_key    (out_match_key),
    .out_probe_handle (out_probe_handle),
    .out_build_handle (out_build_handle),
    .out_last         (out_last)
  );

  hash_join_build_probe_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_match_key     (out_match_key),
    .out_probe_handle  (out_probe_handle),
    .out_build_handle  (out_build_handle),
    .out_last          (out_last),
    .join_errors       (join_errors),
    .joins_outstanding (joins_outstanding)
  );

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one request after an optional idle gap and waits until it is taken.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [HDL_W-1:0] payload);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_key     <= key;
    in_payload <= payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // One join: usually a clear, a build from a small key set, then probes.
  // Stray requests of any kind are mixed in among the build rows.
  task automatic run_join(input int rows, input int probes, input int key_count);
    logic [KEY_W-1:0] key_set [4];
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(5))
        0: key_set[i] = 32'h8000_0000;
        1: key_set[i] = 32'h7FFF_FFFF;
        2: key_set[i] = 32'h0000_0000;
        3: key_set[i] = 32'hFFFF_FFFF;
        default: key_set[i] = $urandom;
      endcase
    end
    if ($urandom_range(9) < 8)
      send_request(KIND_CLEAR, $urandom, $urandom);
    for (int i = 0; i < rows; i++) begin
      if ($urandom_range(9) == 0)
        send_request(KIND_W'($urandom_range(3)), $urandom, $urandom);
      send_request(KIND_INSERT, key_set[$urandom_range(key_count - 1)], $urandom);
    end
    for (int i = 0; i < probes; i++) begin
      if ($urandom_range(4) == 0)
        send_request(KIND_PROBE, $urandom, $urandom);
      else
        send_request(KIND_PROBE, key_set[$urandom_range(key_count - 1)], $urandom);
    end
  endtask

  initial begin
    int               phase_start;
    logic [KEY_W-1:0] fill_key;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme keys and handles, duplicate keys, probes on an empty and a
    // cleared table, a probe without a match and the unused kind.
    send_request(KIND_PROBE,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_request(KIND_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_request(KIND_INSERT, 32'h0000_0000, 32'h8000_0001);
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
    send_request(KIND_PROBE,  32'h8000_0000, 32'hFFFF_FFFF);
    send_request(KIND_PROBE,  32'h7FFF_FFFF, 32'h0000_0000);
    send_request(KIND_PROBE,  32'h0000_0000, 32'hA5A5_A5A5);
    send_request(KIND_PROBE,  32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_request(KIND_PROBE,  32'h0000_0001, 32'h0000_0001);
    send_request(KIND_UNUSED, 32'h8000_0000, 32'hDEAD_BEEF);
    send_request(KIND_PROBE,  32'h8000_0000, 32'h0F0F_0F0F);
    send_request(KIND_CLEAR,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_PROBE,  32'h8000_0000, 32'hF0F0_F0F0);
    send_request(KIND_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_INSERT, 32'h5A5A_5A5A, 32'h0000_0001);
    send_request(KIND_PROBE,  32'h5A5A_5A5A, 32'h8000_0000);
    send_request(KIND_CLEAR,  32'h0000_0000, 32'h0000_0000);

    // Random joins under each idling pattern in turn.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      phase_start = requests_sent;
      // Under back-pressure, fill the table with one key past its depth so that
      // inserts are dropped and each probe returns a full table of matches.
      if (phase == 2) begin
        send_request(KIND_CLEAR, $urandom, $urandom);
        fill_key = $urandom;
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
          send_request(KIND_INSERT, fill_key, $urandom);
        for (int i = 0; i < 2; i++)
          send_request(KIND_PROBE, fill_key, $urandom);
      end
      while (requests_sent - phase_start < 10)
        run_join($urandom_range(1, 12), $urandom_range(1, 4), $urandom_range(1, 4));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (joins_outstanding != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (join_errors == 0 && joins_outstanding == 0)
      $display("hash_join_build_probe: match");
    else
      $display("hash_join_build_probe: mismatch");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("hash_join_build_probe: mismatch");
    $finish;
  end

endmodule
